// ===== rtl/opsd_pkg.sv =====
// Shared constants, types and helper functions of the odd prime sum decomposer.
package opsd_pkg;

   localparam int SIEVE_SIZE = 65536;
   localparam int NUM_W      = 16;
   localparam int MAP_DEPTH  = SIEVE_SIZE / 2;
   localparam int MAP_AW     = $clog2(MAP_DEPTH);
   localparam int SV_W       = $clog2(SIEVE_SIZE) + 2;
   localparam int DIV3_MUL   = 43691;
   localparam int DIV3_SHIFT = 17;

   typedef logic [NUM_W-1:0] num_type;
   typedef logic [1:0]       count_type;

   localparam count_type TERMS_NONE  = 2'd0;
   localparam count_type TERMS_ONE   = 2'd1;
   localparam count_type TERMS_TWO   = 2'd2;
   localparam count_type TERMS_THREE = 2'd3;

   localparam num_type MIN_ODD_PRIME = NUM_W'(3);

   typedef struct packed {
      logic              we;
      logic [MAP_AW-1:0] waddr;
      logic              wdata;
      logic [MAP_AW-1:0] raddr_a;
      logic [MAP_AW-1:0] raddr_b;
   } map_req_type;

   // The map holds odd numbers only; entry k stands for 2k+1.
   function automatic logic [MAP_AW-1:0] map_index(input num_type x);
      return MAP_AW'(x >> 1);
   endfunction

   // Even numbers and numbers beyond the map are never odd primes.
   function automatic logic map_qual(input num_type x);
      return x[0] && (32'(x) < SIEVE_SIZE);
   endfunction

   function automatic num_type odd_down(input num_type v);
      return (v[0] || (v == '0)) ? v : v - NUM_W'(1);
   endfunction

endpackage

// ===== rtl/opsd_if.sv =====
// Request and response channel interfaces of the odd prime sum decomposer.
interface opsd_req_if import opsd_pkg::*; ();
   logic    valid;
   logic    ready;
   num_type number;

   modport source (output valid, output number, input ready);
   modport sink (input valid, input number, output ready);
endinterface

interface opsd_rsp_if import opsd_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type term_count;
   num_type   term_first;
   num_type   term_second;
   num_type   term_third;

   modport source (output valid, output term_count, output term_first,
                   output term_second, output term_third, input ready);
   modport sink (input valid, input term_count, input term_first,
                 input term_second, input term_third, output ready);
endinterface

// ===== rtl/odd_prime_sum_decomposer_core.sv =====
// Top level of the odd prime sum decomposer: sieve, bitmap memory and query search.
//
//   Channel  Direction  Beat contents
//   req_bus  in         number
//   rsp_bus  out        term_count, term_first, term_second, term_third
//
// After reset the sieve fills the bitmap and then marks the multiples of each prime,
// during which req_bus.ready stays low.
// A query that is an odd prime is answered from one bitmap read; otherwise the search
// walks candidate pairs through the two read ports of the bitmap memory, and a
// three-term search first checks each outer candidate; one query is worked at a time.
// A finished response waits in the output register while the next query is taken.
module odd_prime_sum_decomposer_core import opsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   opsd_req_if.sink   req_bus,
   opsd_rsp_if.source rsp_bus
);

   map_req_type sieve_req;
   map_req_type search_req;
   map_req_type map_req;
   logic        sieve_done;
   logic        rd_a;
   logic        rd_b;

   assign map_req = sieve_done ? search_req : sieve_req;

   opsd_map u_map (
      .clock   (clock),
      .map_req (map_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   opsd_sieve u_sieve (
      .clock      (clock),
      .reset      (reset),
      .rd_a       (rd_a),
      .map_req    (sieve_req),
      .sieve_done (sieve_done)
   );

   opsd_search u_search (
      .clock      (clock),
      .reset      (reset),
      .sieve_done (sieve_done),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .map_req    (search_req),
      .rd_a       (rd_a),
      .rd_b       (rd_b)
   );

endmodule

// ===== rtl/opsd_map.sv =====
// Odd prime bitmap memory with one write port and two registered read ports.
module opsd_map import opsd_pkg::*; (
   input  logic        clock,
   input  map_req_type map_req,
   output logic        rd_a,
   output logic        rd_b
);

   logic map_mem [MAP_DEPTH];
   logic rd_a_ff;
   logic rd_b_ff;

   always_ff @(posedge clock) begin
      if (map_req.we) begin
         map_mem[map_req.waddr] <= map_req.wdata;
      end
      rd_a_ff <= map_mem[map_req.raddr_a];
      rd_b_ff <= map_mem[map_req.raddr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// ===== rtl/opsd_sieve.sv =====
// Sieve sequencer that fills the odd prime bitmap after reset.
module opsd_sieve import opsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_a,
   output map_req_type map_req,
   output logic        sieve_done
);

   typedef enum logic [4:0] {
      SV_FILL  = 5'b00001,
      SV_CHECK = 5'b00010,
      SV_TEST  = 5'b00100,
      SV_MARK  = 5'b01000,
      SV_DONE  = 5'b10000
   } sieve_state_type;

   sieve_state_type   state_ff, state_in;
   logic [MAP_AW-1:0] idx_ff, idx_in;
   logic [SV_W-1:0]   i_ff, i_in;
   logic [SV_W-1:0]   sq_ff, sq_in;
   logic [SV_W-1:0]   j_ff, j_in;
   logic [SV_W-1:0]   i_next;
   logic [SV_W-1:0]   sq_next;

   assign i_next  = i_ff + SV_W'(2);
   assign sq_next = sq_ff + (i_ff << 2) + SV_W'(4);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      i_in     = i_ff;
      sq_in    = sq_ff;
      j_in     = j_ff;
      map_req  = '0;
      unique case (state_ff)
         SV_FILL: begin
            // Entry zero stands for one, which is not prime.
            map_req.we    = 1'b1;
            map_req.waddr = idx_ff;
            map_req.wdata = (idx_ff != '0);
            idx_in        = idx_ff + MAP_AW'(1);
            if (idx_ff == MAP_AW'(MAP_DEPTH - 1)) begin
               i_in     = SV_W'(3);
               sq_in    = SV_W'(9);
               state_in = SV_CHECK;
            end
         end
         SV_CHECK: begin
            map_req.raddr_a = MAP_AW'(i_ff >> 1);
            if (sq_ff >= SIEVE_SIZE) begin
               state_in = SV_DONE;
            end else begin
               state_in = SV_TEST;
            end
         end
         SV_TEST: begin
            if (rd_a) begin
               j_in     = sq_ff;
               state_in = SV_MARK;
            end else begin
               i_in     = i_next;
               sq_in    = sq_next;
               state_in = SV_CHECK;
            end
         end
         SV_MARK: begin
            if (j_ff < SIEVE_SIZE) begin
               map_req.we    = 1'b1;
               map_req.waddr = MAP_AW'(j_ff >> 1);
               map_req.wdata = 1'b0;
               j_in          = j_ff + (i_ff << 1);
            end else begin
               i_in     = i_next;
               sq_in    = sq_next;
               state_in = SV_CHECK;
            end
         end
         SV_DONE: begin
            state_in = SV_DONE;
         end
         default: begin
            state_in = SV_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SV_FILL;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
      i_ff  <= i_in;
      sq_ff <= sq_in;
      j_ff  <= j_in;
   end

   assign sieve_done = (state_ff == SV_DONE);

endmodule

// ===== rtl/opsd_search.sv =====
// Query sequencer that searches the bitmap for one, two or three odd prime terms.
module opsd_search import opsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        sieve_done,
   opsd_req_if.sink    req_bus,
   opsd_rsp_if.source  rsp_bus,
   output map_req_type map_req,
   input  logic        rd_a,
   input  logic        rd_b
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_ONE    = 6'b000010,
      S_ACHK   = 6'b000100,
      S_AWAIT  = 6'b001000,
      S_SCAN   = 6'b010000,
      S_FINISH = 6'b100000
   } search_state_type;

   search_state_type state_ff, state_in;
   num_type   n_ff, n_in;
   num_type   x_ff, x_in;
   num_type   s_ff, s_in;
   num_type   lo_ff, lo_in;
   num_type   a_ff, a_in;
   logic      three_ff, three_in;
   logic      chk_q_ff, chk_q_in;
   logic      pend_vld_ff, pend_vld_in;
   num_type   pend_x_ff, pend_x_in;
   num_type   pend_y_ff, pend_y_in;
   logic      pend_q_ff, pend_q_in;
   count_type res_cnt_ff, res_cnt_in;
   num_type   res_t1_ff, res_t1_in;
   num_type   res_t2_ff, res_t2_in;
   num_type   res_t3_ff, res_t3_in;
   logic      rsp_vld_ff, rsp_vld_in;
   count_type rsp_cnt_ff, rsp_cnt_in;
   num_type   rsp_t1_ff, rsp_t1_in;
   num_type   rsp_t2_ff, rsp_t2_in;
   num_type   rsp_t3_ff, rsp_t3_in;

   logic      accept;
   logic      hit;
   logic      issue;
   logic      rsp_free;
   num_type   quot3;
   num_type   diff_na;
   num_type   y_cur;

   assign req_bus.ready = (state_ff == S_IDLE) && sieve_done;
   assign accept        = req_bus.valid && req_bus.ready;
   assign quot3         = NUM_W'((32'(n_ff) * 32'(DIV3_MUL)) >> DIV3_SHIFT);
   assign diff_na       = n_ff - a_ff;
   assign y_cur         = s_ff - x_ff;
   assign hit           = pend_vld_ff && pend_q_ff && rd_a && rd_b;
   assign issue         = (state_ff == S_SCAN) && (x_ff >= lo_ff) && !hit;
   assign rsp_free      = !rsp_vld_ff || rsp_bus.ready;

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      x_in        = x_ff;
      s_in        = s_ff;
      lo_in       = lo_ff;
      a_in        = a_ff;
      three_in    = three_ff;
      chk_q_in    = chk_q_ff;
      pend_vld_in = 1'b0;
      pend_x_in   = pend_x_ff;
      pend_y_in   = pend_y_ff;
      pend_q_in   = pend_q_ff;
      res_cnt_in  = res_cnt_ff;
      res_t1_in   = res_t1_ff;
      res_t2_in   = res_t2_ff;
      res_t3_in   = res_t3_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_bus.ready;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_t1_in   = rsp_t1_ff;
      rsp_t2_in   = rsp_t2_ff;
      rsp_t3_in   = rsp_t3_ff;
      map_req     = '0;
      unique case (state_ff)
         S_IDLE: begin
            map_req.raddr_a = map_index(req_bus.number);
            chk_q_in        = map_qual(req_bus.number);
            if (accept) begin
               n_in     = req_bus.number;
               state_in = S_ONE;
            end
         end
         S_ONE: begin
            res_cnt_in = TERMS_NONE;
            res_t1_in  = '0;
            res_t2_in  = '0;
            res_t3_in  = '0;
            if (chk_q_ff && rd_a) begin
               res_cnt_in = TERMS_ONE;
               res_t1_in  = n_ff;
               state_in   = S_FINISH;
            end else if (!n_ff[0]) begin
               // An odd number is never the sum of two odd primes.
               x_in     = odd_down(n_ff >> 1);
               s_in     = n_ff;
               lo_in    = MIN_ODD_PRIME;
               three_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               // An even number is never the sum of three odd primes.
               three_in = 1'b1;
               a_in     = odd_down(quot3);
               if (odd_down(quot3) >= MIN_ODD_PRIME) begin
                  state_in = S_ACHK;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_ACHK: begin
            map_req.raddr_a = map_index(a_ff);
            chk_q_in        = map_qual(a_ff);
            state_in        = S_AWAIT;
         end
         S_AWAIT: begin
            if (chk_q_ff && rd_a) begin
               s_in     = diff_na;
               x_in     = odd_down(diff_na >> 1);
               lo_in    = a_ff;
               state_in = S_SCAN;
            end else if (a_ff > MIN_ODD_PRIME) begin
               a_in     = a_ff - NUM_W'(2);
               state_in = S_ACHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            map_req.raddr_a = map_index(x_ff);
            map_req.raddr_b = map_index(y_cur);
            pend_vld_in     = issue;
            pend_x_in       = x_ff;
            pend_y_in       = y_cur;
            pend_q_in       = map_qual(x_ff) && map_qual(y_cur);
            if (issue) begin
               x_in = x_ff - NUM_W'(2);
            end
            if (hit) begin
               if (three_ff) begin
                  res_cnt_in = TERMS_THREE;
                  res_t1_in  = a_ff;
                  res_t2_in  = pend_x_ff;
                  res_t3_in  = pend_y_ff;
               end else begin
                  res_cnt_in = TERMS_TWO;
                  res_t1_in  = pend_x_ff;
                  res_t2_in  = pend_y_ff;
                  res_t3_in  = '0;
               end
               state_in = S_FINISH;
            end else if (!issue && !pend_vld_ff) begin
               if (three_ff && (a_ff > MIN_ODD_PRIME)) begin
                  a_in     = a_ff - NUM_W'(2);
                  state_in = S_ACHK;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_cnt_in = res_cnt_ff;
               rsp_t1_in  = res_t1_ff;
               rsp_t2_in  = res_t2_ff;
               rsp_t3_in  = res_t3_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      n_ff       <= n_in;
      x_ff       <= x_in;
      s_ff       <= s_in;
      lo_ff      <= lo_in;
      a_ff       <= a_in;
      three_ff   <= three_in;
      chk_q_ff   <= chk_q_in;
      pend_x_ff  <= pend_x_in;
      pend_y_ff  <= pend_y_in;
      pend_q_ff  <= pend_q_in;
      res_cnt_ff <= res_cnt_in;
      res_t1_ff  <= res_t1_in;
      res_t2_ff  <= res_t2_in;
      res_t3_ff  <= res_t3_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_t1_ff  <= rsp_t1_in;
      rsp_t2_ff  <= rsp_t2_in;
      rsp_t3_ff  <= rsp_t3_in;
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.term_count  = rsp_cnt_ff;
   assign rsp_bus.term_first  = rsp_t1_ff;
   assign rsp_bus.term_second = rsp_t2_ff;
   assign rsp_bus.term_third  = rsp_t3_ff;

endmodule

// ===== rtl/opsd_checker.sv =====
// Port-level checks of the odd prime sum decomposer and their binding to the top level.
module opsd_checker import opsd_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input count_type rsp_term_count,
   input num_type   rsp_term_first,
   input num_type   rsp_term_second,
   input num_type   rsp_term_third
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_term_count)
         && $stable(rsp_term_first) && $stable(rsp_term_second)
         && $stable(rsp_term_third))
      else $error("Stalled response beat changed.");

   a_sieve_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("Query taken or response shown while the sieve runs.");

   a_empty_terms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_term_count == TERMS_NONE) |-> (rsp_term_first == '0)
         && (rsp_term_second == '0) && (rsp_term_third == '0))
      else $error("Response without terms carries nonzero terms.");

   a_two_terms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_term_count == TERMS_TWO) |-> rsp_term_first[0]
         && rsp_term_second[0] && (rsp_term_first <= rsp_term_second)
         && (rsp_term_third == '0))
      else $error("Two-term response is malformed.");

   a_three_terms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_term_count == TERMS_THREE) |-> rsp_term_first[0]
         && rsp_term_second[0] && rsp_term_third[0]
         && (rsp_term_first <= rsp_term_second))
      else $error("Three-term response is malformed.");

endmodule

bind odd_prime_sum_decomposer_core opsd_checker u_opsd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_term_count  (rsp_bus.term_count),
   .rsp_term_first  (rsp_bus.term_first),
   .rsp_term_second (rsp_bus.term_second),
   .rsp_term_third  (rsp_bus.term_third)
);
